// ----- design/owr_pkg.sv -----
// ----------------------------------------------------------------------------
// owr_pkg: shared types for the overwriting ring with offset lookup
// Item structs, ring entry, cell operation codes, controller states and the
// walker control and hit records.
// ----------------------------------------------------------------------------
package owr_pkg;

  // Request kinds
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_FIND = 1'b1;

  localparam int unsigned OffsetW = 20;
  localparam int unsigned SizeW   = 16;
  localparam int unsigned HandleW = 32;

  // Input item
  typedef struct packed {
    logic               req_type;
    logic [SizeW-1:0]   entry_size;
    logic [HandleW-1:0] entry_handle;
    logic [OffsetW-1:0] find_offset;
  } owr_in_t;

  // Result item
  typedef struct packed {
    logic               found;
    logic [HandleW-1:0] hit_handle;
    logic [SizeW-1:0]   hit_size;
    logic [SizeW-1:0]   byte_in_entry;
    logic               evicted_valid;
    logic [HandleW-1:0] evicted_handle;
    logic               ring_full;
  } owr_out_t;

  // One stored entry
  typedef struct packed {
    logic [SizeW-1:0]   size;
    logic [HandleW-1:0] handle;
  } entry_t;

  // What a cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT
  } cell_op_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } owr_state_e;

  // Walker control from the controller
  typedef struct packed {
    logic clear;
    logic step;
  } walk_ctl_t;

  // Walker match record
  typedef struct packed {
    logic               found;
    logic [HandleW-1:0] handle;
    logic [SizeW-1:0]   size;
    logic [SizeW-1:0]   byte_idx;
  } hit_t;

endpackage

// ----- design/owr_cell.sv -----
// ----------------------------------------------------------------------------
// owr_cell: one ring slot
// Holds one entry; loads a new entry or takes its neighbor's entry on a
// shift or rotation.
// ----------------------------------------------------------------------------
module owr_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  owr_pkg::cell_op_e op_i,
  input  owr_pkg::entry_t   new_i,
  input  owr_pkg::entry_t   nb_i,
  output owr_pkg::entry_t   entry_o
);
  import owr_pkg::*;

  entry_t entry_d, entry_q;

  // Next entry
  always_comb begin
    case (op_i)
      CELL_HOLD:  entry_d = entry_q;
      CELL_LOAD:  entry_d = new_i;
      CELL_SHIFT: entry_d = nb_i;
      default:    entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

// ----- design/owr_walker.sv -----
// ----------------------------------------------------------------------------
// owr_walker: running size sum and match capture for a find
// Sees the oldest-position cell once per rotation step and latches the first
// entry whose byte range covers the requested offset.
// ----------------------------------------------------------------------------
module owr_walker #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  owr_pkg::walk_ctl_t               ctl_i,
  input  owr_pkg::entry_t                  head_i,
  input  logic [owr_pkg::OffsetW-1:0]      offset_i,
  output owr_pkg::hit_t                    hit_o
);
  import owr_pkg::*;

  // Sum of all sizes fits in SeenW bits
  localparam int unsigned SeenW = SizeW + $clog2(SLOTS);
  localparam int unsigned CmpW  = (SeenW > OffsetW) ? SeenW : OffsetW;

  logic [SeenW-1:0] seen_d, seen_q;
  hit_t             hit_d, hit_q;
  logic [CmpW-1:0]  off_ext, seen_ext, sum_ext, diff;

  assign off_ext  = CmpW'(offset_i);
  assign seen_ext = CmpW'(seen_q);
  assign sum_ext  = seen_ext + CmpW'(head_i.size);
  assign diff     = off_ext - seen_ext;

  // Accumulate, stop at the first covering entry
  always_comb begin
    seen_d = seen_q;
    hit_d  = hit_q;
    if (ctl_i.clear) begin
      seen_d = '0;
      hit_d  = '0;
    end else if (ctl_i.step && !hit_q.found) begin
      if (off_ext < sum_ext) begin
        hit_d.found    = 1'b1;
        hit_d.handle   = head_i.handle;
        hit_d.size     = head_i.size;
        hit_d.byte_idx = diff[SizeW-1:0];
      end else begin
        seen_d = sum_ext[SeenW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      hit_q  <= '0;
    end else begin
      seen_q <= seen_d;
      hit_q  <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule

// ----- design/overwrite_ring_with_offset_lookup.sv -----
// ----------------------------------------------------------------------------
// overwrite_ring_with_offset_lookup: overwriting entry ring with offset find
// Cells hold entries oldest first; an add loads or shifts the row, a find
// rotates the row once around past the walker that sums sizes.
// ----------------------------------------------------------------------------
// Add: result registered at the accepting edge, visible the next cycle;
//   one add per cycle while results are taken.
// Find: the row rotates through every slot in ST_WALK, then ST_DONE loads
//   the result once it can be taken; the next item is taken back in ST_IDLE.
// The find time is set by the cell row rotating one slot per cycle.
// Reset clears all cells, the entry count and the output valid flag.
module overwrite_ring_with_offset_lookup #(
  parameter int unsigned SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  owr_pkg::owr_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output owr_pkg::owr_out_t out_item_o
);
  import owr_pkg::*;

  localparam int unsigned CntW = $clog2(SLOTS + 1);

  owr_state_e       state_d, state_q;
  logic [CntW-1:0]  count_d, count_q;
  logic [CntW-1:0]  step_d, step_q;
  logic [OffsetW-1:0] offset_q;
  owr_out_t         out_d, out_q;
  logic             out_valid_q;
  logic             out_load, can_take, in_accept, is_full, last_step;

  cell_op_e         cell_op [SLOTS];
  entry_t           cell_q [SLOTS];
  entry_t           new_entry;
  walk_ctl_t        walk_ctl;
  hit_t             hit;

  assign is_full   = (count_q == CntW'(SLOTS));
  assign last_step = (step_q == CntW'(SLOTS - 1));
  assign can_take  = !out_valid_q || !out_stall_i;
  assign in_accept = in_valid_i && !in_stall_o;
  assign new_entry = '{size: in_item_i.entry_size, handle: in_item_i.entry_handle};

  // Cell row, each cell takes from the next younger one (wraps on rotation)
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    owr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (cell_op[g]),
      .new_i   (new_entry),
      .nb_i    (cell_q[(g + 1) % SLOTS]),
      .entry_o (cell_q[g])
    );
  end

  // Size walker at the oldest cell
  owr_walker #(.SLOTS(SLOTS)) u_walker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (walk_ctl),
    .head_i   (cell_q[0]),
    .offset_i (offset_q),
    .hit_o    (hit)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_accept && in_item_i.req_type == REQ_FIND) state_d = ST_WALK;
      ST_WALK: if (last_step) state_d = ST_DONE;
      ST_DONE: if (can_take) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: stall, cell ops, walker control, result loading
  always_comb begin
    in_stall_o = !(state_q == ST_IDLE && can_take);
    for (int i = 0; i < SLOTS; i++) cell_op[i] = CELL_HOLD;
    walk_ctl = '0;
    out_load = 1'b0;
    out_d    = '0;
    count_d  = count_q;
    step_d   = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_item_i.req_type == REQ_ADD) begin
            out_load = 1'b1;
            if (is_full) begin
              // Drop the oldest, shift the row, new entry at the young end
              for (int i = 0; i < SLOTS - 1; i++) cell_op[i] = CELL_SHIFT;
              cell_op[SLOTS-1]     = CELL_LOAD;
              out_d.evicted_valid  = 1'b1;
              out_d.evicted_handle = cell_q[0].handle;
              out_d.ring_full      = 1'b1;
            end else begin
              for (int i = 0; i < SLOTS; i++) begin
                if (count_q == CntW'(i)) cell_op[i] = CELL_LOAD;
              end
              count_d         = count_q + CntW'(1);
              out_d.ring_full = (count_d == CntW'(SLOTS));
            end
          end else begin
            walk_ctl.clear = 1'b1;
            step_d         = '0;
          end
        end
      end
      ST_WALK: begin
        // Full rotation restores the order
        for (int i = 0; i < SLOTS; i++) cell_op[i] = CELL_SHIFT;
        walk_ctl.step = (step_q < count_q);
        step_d        = step_q + CntW'(1);
      end
      ST_DONE: begin
        if (can_take) begin
          out_load            = 1'b1;
          out_d.found         = hit.found;
          out_d.hit_handle    = hit.handle;
          out_d.hit_size      = hit.size;
          out_d.byte_in_entry = hit.byte_idx;
          out_d.ring_full     = is_full;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      step_q  <= step_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) offset_q <= in_item_i.find_offset;
    if (out_load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(SLOTS))
    else $error("entry count above ring size");

  a_walk_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> step_q < CntW'(SLOTS))
    else $error("walk step out of range");

  a_done_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_DONE) |-> $past(state_q) == ST_WALK && $past(last_step))
    else $error("find finished before a full rotation");

  a_full_add_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_item_i.req_type == REQ_ADD && is_full |=> is_full)
    else $error("overwrite changed entry count");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("loaded item not presented");

endmodule
